>>> design/mjsa_pkg.sv
package mjsa_pkg;

	// Request opcodes
	localparam logic [1:0] OP_HDR  = 2'd0;
	localparam logic [1:0] OP_ELEM = 2'd1;
	localparam logic [1:0] OP_NODE = 2'd2;

	// Fixed field widths
	localparam int POS_W = 17;
	localparam int WGT_W = 32;
	localparam int ELM_W = 16;
	localparam int ACC_W = 48;
	localparam int JC_W  = 9;
	localparam int IDX_W = 8;
	localparam int RC_W  = 2;

	// Commands from controller to datapath
	typedef struct packed {
		logic            hdr_wr;
		logic            elem_wr;
		logic            node_start;
		logic            look;
		logic            issue;
		logic [RC_W-1:0] row;
		logic [RC_W-1:0] col;
		logic            last;
	} mjsa_cmd_t;

	// Status from datapath to controller
	typedef struct packed {
		logic s1_busy;
		logic s2_busy;
		logic adv;
	} mjsa_stat_t;

endpackage

>>> design/mjsa_ctrl.sv
module mjsa_ctrl #(
	parameter int DIM = 2
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	input  logic [1:0]           op,
	output logic                 in_stall,
	input  mjsa_pkg::mjsa_stat_t stat,
	output mjsa_pkg::mjsa_cmd_t  cmd
);

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_LOOK = 2'd1;
	localparam logic [1:0] S_RUN  = 2'd2;

	localparam logic [mjsa_pkg::RC_W-1:0] LAST_RC = mjsa_pkg::RC_W'(DIM - 1);

	logic [1:0]                  state_q;
	logic [mjsa_pkg::RC_W-1:0]   row_q;
	logic [mjsa_pkg::RC_W-1:0]   col_q;
	logic                        accept;
	logic                        last_elem;

	// Take a request only with the element pipeline drained
	assign in_stall  = (state_q != S_IDLE) || stat.s1_busy || stat.s2_busy;
	assign accept    = in_valid && !in_stall;
	assign last_elem = (row_q == LAST_RC) && (col_q == LAST_RC);

	always_comb begin
		cmd            = '0;
		cmd.row        = row_q;
		cmd.col        = col_q;
		cmd.last       = last_elem;
		cmd.hdr_wr     = accept && (op == mjsa_pkg::OP_HDR);
		cmd.elem_wr    = accept && (op == mjsa_pkg::OP_ELEM);
		cmd.node_start = accept && (op == mjsa_pkg::OP_NODE);
		cmd.look       = (state_q == S_LOOK);
		cmd.issue      = (state_q == S_RUN) && stat.adv;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			row_q   <= '0;
			col_q   <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (cmd.node_start) begin
						state_q <= S_LOOK;
					end
				end
				S_LOOK: begin
					row_q   <= '0;
					col_q   <= '0;
					state_q <= S_RUN;
				end
				S_RUN: begin
					if (stat.adv) begin
						if (last_elem) begin
							state_q <= S_IDLE;
						end else if (col_q == LAST_RC) begin
							col_q <= '0;
							row_q <= row_q + 1'b1;
						end else begin
							col_q <= col_q + 1'b1;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

>>> design/mjsa_dpath.sv
module mjsa_dpath #(
	parameter int DIM       = 2,
	parameter int MAX_JUMPS = 256
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  mjsa_pkg::mjsa_cmd_t                 cmd,
	output mjsa_pkg::mjsa_stat_t                stat,
	input  logic                                cfg_valid,
	input  logic [mjsa_pkg::JC_W-1:0]           cfg_data,
	input  logic [mjsa_pkg::IDX_W-1:0]          jump_index,
	input  logic [mjsa_pkg::POS_W-1:0]          jump_pos,
	input  logic signed [mjsa_pkg::WGT_W-1:0]   jump_weight,
	input  logic [mjsa_pkg::RC_W-1:0]           row,
	input  logic [mjsa_pkg::RC_W-1:0]           col,
	input  logic signed [mjsa_pkg::ELM_W-1:0]   elem_re,
	input  logic signed [mjsa_pkg::ELM_W-1:0]   elem_im,
	input  logic [mjsa_pkg::POS_W-1:0]          node_pos,
	input  logic                                first_node,
	input  logic                                out_stall,
	output logic                                out_valid,
	output logic [mjsa_pkg::RC_W-1:0]           out_row,
	output logic [mjsa_pkg::RC_W-1:0]           out_col,
	output logic signed [mjsa_pkg::ACC_W-1:0]   sum_re,
	output logic signed [mjsa_pkg::ACC_W-1:0]   sum_im,
	output logic                                last
);

	localparam int CELLS   = DIM * DIM;
	localparam int CELL_W  = (CELLS > 1) ? $clog2(CELLS) : 1;
	localparam int JIDX_W  = (MAX_JUMPS > 1) ? $clog2(MAX_JUMPS) : 1;
	localparam int NJ_W    = $clog2(MAX_JUMPS + 1);
	localparam int LIM_W   = (NJ_W > mjsa_pkg::JC_W) ? NJ_W : mjsa_pkg::JC_W;
	localparam int MDEPTH  = MAX_JUMPS * CELLS;
	localparam int MADDR_W = (MDEPTH > 1) ? $clog2(MDEPTH) : 1;
	localparam int ACC_W   = mjsa_pkg::ACC_W;
	localparam int ELM_W   = mjsa_pkg::ELM_W;

	localparam logic signed [ACC_W-1:0] SAT_HI = {1'b0, {(ACC_W-1){1'b1}}};
	localparam logic signed [ACC_W-1:0] SAT_LO = {1'b1, {(ACC_W-1){1'b0}}};

	// Tables
	logic [mjsa_pkg::POS_W-1:0]        pos_mem [MAX_JUMPS];
	logic signed [mjsa_pkg::WGT_W-1:0] wgt_mem [MAX_JUMPS];
	logic [2*ELM_W-1:0]                mat_mem [MDEPTH];

	logic [mjsa_pkg::JC_W-1:0]         jump_count_q;
	logic [NJ_W-1:0]                   next_jump_q;
	logic [JIDX_W-1:0]                 rd_idx_q;
	logic [mjsa_pkg::POS_W-1:0]        node_pos_q;
	logic [mjsa_pkg::POS_W-1:0]        pos_rd_q;
	logic signed [mjsa_pkg::WGT_W-1:0] wgt_rd_q;
	logic signed [mjsa_pkg::WGT_W-1:0] wgt_q;
	logic                              hit_q;

	logic signed [ACC_W-1:0]           acc_re_q [CELLS];
	logic signed [ACC_W-1:0]           acc_im_q [CELLS];

	// Element pipeline
	logic                              v_s1;
	logic [2*ELM_W-1:0]                m_s1;
	logic [CELL_W-1:0]                 cell_s1;
	logic [mjsa_pkg::RC_W-1:0]         row_s1;
	logic [mjsa_pkg::RC_W-1:0]         col_s1;
	logic                              last_s1;
	logic                              v_s2;
	logic signed [ACC_W-1:0]           p_re_s2;
	logic signed [ACC_W-1:0]           p_im_s2;
	logic [CELL_W-1:0]                 cell_s2;
	logic [mjsa_pkg::RC_W-1:0]         row_s2;
	logic [mjsa_pkg::RC_W-1:0]         col_s2;
	logic                              last_s2;
	logic                              out_valid_q;

	logic                              adv;
	logic                              hdr_ok;
	logic                              elem_ok;
	logic [JIDX_W-1:0]                 wr_idx;
	logic [MADDR_W-1:0]                wr_addr;
	logic [MADDR_W-1:0]                rd_addr;
	logic [CELL_W-1:0]                 issue_cell;
	logic [JIDX_W-1:0]                 hdr_addr;
	logic [LIM_W-1:0]                  jc_ext;
	logic [LIM_W-1:0]                  limit;
	logic                              hit;
	logic signed [ELM_W-1:0]           m_re;
	logic signed [ELM_W-1:0]           m_im;
	logic signed [ACC_W-1:0]           prod_re;
	logic signed [ACC_W-1:0]           prod_im;
	logic signed [ACC_W-1:0]           new_re;
	logic signed [ACC_W-1:0]           new_im;

	function automatic logic signed [ACC_W-1:0] sat_add(
		input logic signed [ACC_W-1:0] a,
		input logic signed [ACC_W-1:0] b
	);
		logic signed [ACC_W:0] s;
		s = {a[ACC_W-1], a} + {b[ACC_W-1], b};
		if (s[ACC_W] != s[ACC_W-1]) begin
			return s[ACC_W] ? SAT_LO : SAT_HI;
		end
		return s[ACC_W-1:0];
	endfunction

	// Whole pipeline moves when the output register can take a new element
	assign adv  = !out_valid_q || !out_stall;
	assign stat = '{s1_busy: v_s1, s2_busy: v_s2, adv: adv};

	// Write decode; drop out-of-range indexes
	assign wr_idx  = JIDX_W'(jump_index);
	assign hdr_ok  = int'(jump_index) < MAX_JUMPS;
	assign elem_ok = hdr_ok && (int'(row) < DIM) && (int'(col) < DIM);
	assign wr_addr = MADDR_W'(wr_idx) * MADDR_W'(CELLS)
		+ MADDR_W'(row) * MADDR_W'(DIM) + MADDR_W'(col);

	assign issue_cell = CELL_W'(cmd.row) * CELL_W'(DIM) + CELL_W'(cmd.col);
	assign rd_addr    = MADDR_W'(rd_idx_q) * MADDR_W'(CELLS) + MADDR_W'(issue_cell);
	assign hdr_addr   = first_node ? '0 : next_jump_q[JIDX_W-1:0];

	assign jc_ext = LIM_W'(jump_count_q);
	assign limit  = (jc_ext > LIM_W'(MAX_JUMPS)) ? LIM_W'(MAX_JUMPS) : jc_ext;
	assign hit    = (LIM_W'(next_jump_q) < limit) && (pos_rd_q <= node_pos_q);

	assign m_re    = m_s1[ELM_W-1:0];
	assign m_im    = m_s1[2*ELM_W-1:ELM_W];
	assign prod_re = ACC_W'(wgt_q) * ACC_W'(m_re);
	assign prod_im = ACC_W'(wgt_q) * ACC_W'(m_im);

	assign new_re = sat_add(acc_re_q[cell_s2], p_re_s2);
	assign new_im = sat_add(acc_im_q[cell_s2], p_im_s2);

	// Header table: one write or one read per cycle
	always_ff @(posedge clk) begin
		if (cmd.hdr_wr && hdr_ok) begin
			pos_mem[wr_idx] <= jump_pos;
			wgt_mem[wr_idx] <= jump_weight;
		end
		if (cmd.node_start) begin
			pos_rd_q <= pos_mem[hdr_addr];
			wgt_rd_q <= wgt_mem[hdr_addr];
			rd_idx_q <= hdr_addr;
			node_pos_q <= node_pos;
		end
		if (cmd.look) begin
			wgt_q <= wgt_rd_q;
		end
	end

	// Matrix table
	always_ff @(posedge clk) begin
		if (cmd.elem_wr && elem_ok) begin
			mat_mem[wr_addr] <= {elem_im, elem_re};
		end
		if (cmd.issue) begin
			m_s1    <= mat_mem[rd_addr];
			cell_s1 <= issue_cell;
			row_s1  <= cmd.row;
			col_s1  <= cmd.col;
			last_s1 <= cmd.last;
		end
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			jump_count_q <= '0;
			next_jump_q  <= '0;
			hit_q        <= 1'b0;
			v_s1         <= 1'b0;
			v_s2         <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cfg_valid) begin
				jump_count_q <= cfg_data;
			end
			if (cmd.node_start && first_node) begin
				next_jump_q <= '0;
			end else if (cmd.look && hit) begin
				next_jump_q <= next_jump_q + 1'b1;
			end
			if (cmd.look) begin
				hit_q <= hit;
			end
			if (adv) begin
				v_s1        <= cmd.issue;
				v_s2        <= v_s1;
				out_valid_q <= v_s2;
			end
		end
	end

	// Product stage; a miss adds zero
	always_ff @(posedge clk) begin
		if (adv && v_s1) begin
			p_re_s2 <= hit_q ? prod_re : '0;
			p_im_s2 <= hit_q ? prod_im : '0;
			cell_s2 <= cell_s1;
			row_s2  <= row_s1;
			col_s2  <= col_s1;
			last_s2 <= last_s1;
		end
	end

	// Running sums
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < CELLS; k++) begin
				acc_re_q[k] <= '0;
				acc_im_q[k] <= '0;
			end
		end else if (cmd.node_start && first_node) begin
			for (int k = 0; k < CELLS; k++) begin
				acc_re_q[k] <= '0;
				acc_im_q[k] <= '0;
			end
		end else if (adv && v_s2) begin
			acc_re_q[cell_s2] <= new_re;
			acc_im_q[cell_s2] <= new_im;
		end
	end

	// Output register
	always_ff @(posedge clk) begin
		if (adv && v_s2) begin
			out_row <= row_s2;
			out_col <= col_s2;
			sum_re  <= new_re;
			sum_im  <= new_im;
			last    <= last_s2;
		end
	end

	assign out_valid = out_valid_q;

endmodule

>>> design/matrix_jump_step_accumulate_unit.sv
// Jump-step matrix accumulator. Load jump headers (op 0: position Q1.16, weight
// Q15.16) and matrix elements (op 1: complex Q1.14, row and column) into the
// tables, write jump_count on the configuration port, then stream node
// requests (op 2) in ascending position order. For each node the block adds
// weight times the next unused jump's matrix to the running complex sum when
// that jump lies at or before the node (at most one jump per node), and
// returns the whole sum as DIM*DIM results in row-major order, Q17.30, each
// part saturated to 48 bits, with last on the final element. first_node
// clears the sum and restarts at the first jump. A table write leaves the
// channel free for the next request. A node request holds the channel
// through a header read, then one matrix-table read per element through a
// single read port, a multiply stage and an accumulate stage that must
// drain before the next request. Table contents are undefined until
// written; there is no clearing pass after reset. Reading a never-written
// entry is not allowed.
module matrix_jump_step_accumulate_unit #(
	parameter int DIM       = 2,
	parameter int MAX_JUMPS = 256
) (
	input  logic                                clk,
	input  logic                                arst_n,
	// request channel
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic [1:0]                          op,
	input  logic [mjsa_pkg::IDX_W-1:0]          jump_index,
	input  logic [mjsa_pkg::POS_W-1:0]          jump_pos,
	input  logic signed [mjsa_pkg::WGT_W-1:0]   jump_weight,
	input  logic [mjsa_pkg::RC_W-1:0]           row,
	input  logic [mjsa_pkg::RC_W-1:0]           col,
	input  logic signed [mjsa_pkg::ELM_W-1:0]   elem_re,
	input  logic signed [mjsa_pkg::ELM_W-1:0]   elem_im,
	input  logic [mjsa_pkg::POS_W-1:0]          node_pos,
	input  logic                                first_node,
	// result channel
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic [mjsa_pkg::RC_W-1:0]           out_row,
	output logic [mjsa_pkg::RC_W-1:0]           out_col,
	output logic signed [mjsa_pkg::ACC_W-1:0]   sum_re,
	output logic signed [mjsa_pkg::ACC_W-1:0]   sum_im,
	output logic                                last,
	// jump_count write
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [mjsa_pkg::JC_W-1:0]           cfg_data
);

	mjsa_pkg::mjsa_cmd_t  cmd;
	mjsa_pkg::mjsa_stat_t stat;

	// The count register takes a write in any cycle
	assign cfg_ready = 1'b1;

	// Sequence requests: decode ops, hold the header lookup, step the elements
	mjsa_ctrl #(
		.DIM(DIM)
	) u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_valid),
		.op      (op),
		.in_stall(in_stall),
		.stat    (stat),
		.cmd     (cmd)
	);

	// Tables, jump pointer, multiply and saturating accumulate, output register
	mjsa_dpath #(
		.DIM      (DIM),
		.MAX_JUMPS(MAX_JUMPS)
	) u_dpath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.stat       (stat),
		.cfg_valid  (cfg_valid),
		.cfg_data   (cfg_data),
		.jump_index (jump_index),
		.jump_pos   (jump_pos),
		.jump_weight(jump_weight),
		.row        (row),
		.col        (col),
		.elem_re    (elem_re),
		.elem_im    (elem_im),
		.node_pos   (node_pos),
		.first_node (first_node),
		.out_stall  (out_stall),
		.out_valid  (out_valid),
		.out_row    (out_row),
		.out_col    (out_col),
		.sum_re     (sum_re),
		.sum_im     (sum_im),
		.last       (last)
	);

endmodule

>>> design/mjsa_check.sv
module mjsa_check (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              in_valid,
	input logic                              in_stall,
	input logic [1:0]                        op,
	input logic                              out_valid,
	input logic                              out_stall,
	input logic [mjsa_pkg::RC_W-1:0]         out_row,
	input logic [mjsa_pkg::RC_W-1:0]         out_col,
	input logic signed [mjsa_pkg::ACC_W-1:0] sum_re,
	input logic signed [mjsa_pkg::ACC_W-1:0] sum_im,
	input logic                              last
);

	// A stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(sum_re) && $stable(sum_im)
			&& $stable(out_row) && $stable(out_col) && $stable(last))
		else $error("stalled result changed");

	// A node request blocks the channel while its lookup runs
	a_node_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && op == mjsa_pkg::OP_NODE |=> in_stall)
		else $error("request taken during node lookup");

	// A table write leaves the block ready for the next request
	a_write_ready: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && op != mjsa_pkg::OP_NODE |=> !in_stall)
		else $error("stall after table write");

	// The final element sits on the diagonal corner
	a_last_corner: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && last |-> out_row == out_col)
		else $error("last flag off the corner element");

	// No result follows the final element in the next cycle
	a_last_gap: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && last |=> !out_valid)
		else $error("result right after final element");

endmodule

bind matrix_jump_step_accumulate_unit mjsa_check u_mjsa_check (
	.clk      (clk),
	.arst_n   (arst_n),
	.in_valid (in_valid),
	.in_stall (in_stall),
	.op       (op),
	.out_valid(out_valid),
	.out_stall(out_stall),
	.out_row  (out_row),
	.out_col  (out_col),
	.sum_re   (sum_re),
	.sum_im   (sum_im),
	.last     (last)
);

>>> test/jump_sum_checker.sv
module jump_sum_checker #(
	parameter int DIM       = 2,
	parameter int MAX_JUMPS = 256
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	input  logic                                in_stall,
	input  logic [1:0]                          op,
	input  logic [mjsa_pkg::IDX_W-1:0]          jump_index,
	input  logic [mjsa_pkg::POS_W-1:0]          jump_pos,
	input  logic signed [mjsa_pkg::WGT_W-1:0]   jump_weight,
	input  logic [mjsa_pkg::RC_W-1:0]           row,
	input  logic [mjsa_pkg::RC_W-1:0]           col,
	input  logic signed [mjsa_pkg::ELM_W-1:0]   elem_re,
	input  logic signed [mjsa_pkg::ELM_W-1:0]   elem_im,
	input  logic [mjsa_pkg::POS_W-1:0]          node_pos,
	input  logic                                first_node,
	input  logic                                out_valid,
	input  logic                                out_stall,
	input  logic [mjsa_pkg::RC_W-1:0]           out_row,
	input  logic [mjsa_pkg::RC_W-1:0]           out_col,
	input  logic signed [mjsa_pkg::ACC_W-1:0]   sum_re,
	input  logic signed [mjsa_pkg::ACC_W-1:0]   sum_im,
	input  logic                                last,
	input  logic                                cfg_valid,
	input  logic                                cfg_ready,
	input  logic [mjsa_pkg::JC_W-1:0]           cfg_data,
	output int                                  fail_count,
	output int                                  results_due
);
	import mjsa_pkg::*;

	localparam int CELLS = DIM * DIM;
	localparam logic signed [ACC_W:0] SUM_MAX = 49'sh0_7FFF_FFFF_FFFF;
	localparam logic signed [ACC_W:0] SUM_MIN = 49'sh1_8000_0000_0000;

	typedef struct packed {
		logic [RC_W-1:0]         r;
		logic [RC_W-1:0]         c;
		logic signed [ACC_W-1:0] re;
		logic signed [ACC_W-1:0] im;
		logic                    last;
	} sum_elem_t;

	sum_elem_t sums_due[$];

	logic [POS_W-1:0]        jump_pos_tab [MAX_JUMPS];
	logic signed [WGT_W-1:0] jump_wgt_tab [MAX_JUMPS];
	logic signed [ELM_W-1:0] elem_re_tab  [MAX_JUMPS*CELLS];
	logic signed [ELM_W-1:0] elem_im_tab  [MAX_JUMPS*CELLS];
	logic signed [ACC_W-1:0] sum_re_acc   [CELLS];
	logic signed [ACC_W-1:0] sum_im_acc   [CELLS];
	int                      jump_ptr;
	logic [JC_W-1:0]         jump_cnt;

	function automatic logic signed [ACC_W-1:0] sat_sum(input logic signed [ACC_W-1:0] a,
			input logic signed [ACC_W-1:0] b);
		logic signed [ACC_W:0] s;
		s = a + b;
		if (s > SUM_MAX) return SUM_MAX[ACC_W-1:0];
		if (s < SUM_MIN) return SUM_MIN[ACC_W-1:0];
		return s[ACC_W-1:0];
	endfunction

	task automatic flag(input string what);
		fail_count++;
		$display("[%0t] ERROR %s", $time, what);
	endtask

	// add at most one jump, then queue the whole sum in row-major order
	task automatic accumulate_node(input logic [POS_W-1:0] npos, input logic first);
		int lim;
		int b;
		logic signed [ACC_W-1:0] w;
		logic signed [ACC_W-1:0] m;
		sum_elem_t e;
		if (first) begin
			for (int k = 0; k < CELLS; k++) begin
				sum_re_acc[k] = '0;
				sum_im_acc[k] = '0;
			end
			jump_ptr = 0;
		end
		lim = (jump_cnt > MAX_JUMPS) ? MAX_JUMPS : int'(jump_cnt);
		if (jump_ptr < lim && jump_pos_tab[jump_ptr] <= npos) begin
			w = jump_wgt_tab[jump_ptr];
			b = jump_ptr * CELLS;
			for (int k = 0; k < CELLS; k++) begin
				m = elem_re_tab[b + k];
				sum_re_acc[k] = sat_sum(sum_re_acc[k], w * m);
				m = elem_im_tab[b + k];
				sum_im_acc[k] = sat_sum(sum_im_acc[k], w * m);
			end
			jump_ptr++;
		end
		for (int k = 0; k < CELLS; k++) begin
			e.r = RC_W'(k / DIM);
			e.c = RC_W'(k % DIM);
			e.re = sum_re_acc[k];
			e.im = sum_im_acc[k];
			e.last = (k == CELLS - 1);
			sums_due.push_back(e);
		end
	endtask

	task automatic check_result();
		sum_elem_t want;
		if (sums_due.size() == 0) begin
			flag($sformatf("result (%0d,%0d) with no node outstanding", out_row, out_col));
			return;
		end
		want = sums_due.pop_front();
		if (out_row !== want.r || out_col !== want.c)
			flag($sformatf("position got (%0d,%0d) want (%0d,%0d)",
				out_row, out_col, want.r, want.c));
		if (sum_re !== want.re)
			flag($sformatf("sum_re at (%0d,%0d) got %0d want %0d",
				want.r, want.c, sum_re, want.re));
		if (sum_im !== want.im)
			flag($sformatf("sum_im at (%0d,%0d) got %0d want %0d",
				want.r, want.c, sum_im, want.im));
		if (last !== want.last)
			flag($sformatf("last at (%0d,%0d) got %b want %b", want.r, want.c, last, want.last));
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sums_due.delete();
			for (int k = 0; k < CELLS; k++) begin
				sum_re_acc[k] = '0;
				sum_im_acc[k] = '0;
			end
			jump_ptr = 0;
			jump_cnt = '0;
			fail_count = 0;
			results_due = 0;
		end else begin
			if (out_valid && !out_stall)
				check_result();
			if (cfg_valid && cfg_ready)
				jump_cnt = cfg_data;
			if (in_valid && !in_stall) begin
				case (op)
					OP_HDR: begin
						jump_pos_tab[jump_index] = jump_pos;
						jump_wgt_tab[jump_index] = jump_weight;
					end
					OP_ELEM: begin
						if (row < DIM && col < DIM) begin
							elem_re_tab[jump_index*CELLS + row*DIM + col] = elem_re;
							elem_im_tab[jump_index*CELLS + row*DIM + col] = elem_im;
						end
					end
					OP_NODE: accumulate_node(node_pos, first_node);
					default: ;
				endcase
			end
			results_due = sums_due.size();
		end
	end

endmodule

>>> test/tb.sv
module tb;
	import mjsa_pkg::*;

	localparam int DIM       = 2;
	localparam int MAX_JUMPS = 256;
	localparam int CELLS     = DIM * DIM;

	// the one opcode the block does nothing with
	localparam logic [1:0] OP_SPARE = 2'd3;

	localparam int RANDOM_ITEMS   = 300;
	localparam int HOLD_CYCLES    = 300;  // long receiver hold-off
	localparam int DRAIN_CYCLES   = 16;   // table writes in flight before a cfg write
	localparam int TAIL_CYCLES    = 40;
	localparam int WATCHDOG_LIMIT = 3000;

	typedef struct packed {
		logic [1:0]              op;
		logic [IDX_W-1:0]        idx;
		logic [POS_W-1:0]        jpos;
		logic signed [WGT_W-1:0] wgt;
		logic [RC_W-1:0]         r;
		logic [RC_W-1:0]         c;
		logic signed [ELM_W-1:0] re;
		logic signed [ELM_W-1:0] im;
		logic [POS_W-1:0]        npos;
		logic                    first;
	} req_t;

	logic                    clk = 1'b0;
	logic                    arst_n = 1'b0;
	logic                    in_valid = 1'b0;
	logic                    in_stall;
	logic [1:0]              op = '0;
	logic [IDX_W-1:0]        jump_index = '0;
	logic [POS_W-1:0]        jump_pos = '0;
	logic signed [WGT_W-1:0] jump_weight = '0;
	logic [RC_W-1:0]         row = '0;
	logic [RC_W-1:0]         col = '0;
	logic signed [ELM_W-1:0] elem_re = '0;
	logic signed [ELM_W-1:0] elem_im = '0;
	logic [POS_W-1:0]        node_pos = '0;
	logic                    first_node = 1'b0;
	logic                    out_valid;
	logic                    out_stall = 1'b0;
	logic [RC_W-1:0]         out_row;
	logic [RC_W-1:0]         out_col;
	logic signed [ACC_W-1:0] sum_re;
	logic signed [ACC_W-1:0] sum_im;
	logic                    last;
	logic                    cfg_valid = 1'b0;
	logic                    cfg_ready;
	logic [JC_W-1:0]         cfg_data = '0;

	int fail_count;
	int results_due;

	// Stimulus-side view of the tables, kept only so that no node ever
	// reads a jump entry or matrix element that was never written.
	logic             hdr_seen   [MAX_JUMPS];
	logic [CELLS-1:0] cells_seen [MAX_JUMPS];
	logic [POS_W-1:0] pos_seen   [MAX_JUMPS];
	int               ptr_seen = 0;
	int               count_seen = 0;
	int               items_sent = 0;

	logic send_calm = 1'b0;  // sender offers back to back
	logic recv_calm = 1'b0;  // receiver never stalls
	logic hold_req = 1'b0;   // ask the receiver for one long hold-off
	int   quiet = 0;

	matrix_jump_step_accumulate_unit #(
		.DIM       (DIM),
		.MAX_JUMPS (MAX_JUMPS)
	) dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.op          (op),
		.jump_index  (jump_index),
		.jump_pos    (jump_pos),
		.jump_weight (jump_weight),
		.row         (row),
		.col         (col),
		.elem_re     (elem_re),
		.elem_im     (elem_im),
		.node_pos    (node_pos),
		.first_node  (first_node),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.out_row     (out_row),
		.out_col     (out_col),
		.sum_re      (sum_re),
		.sum_im      (sum_im),
		.last        (last),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_data    (cfg_data)
	);

	jump_sum_checker #(
		.DIM       (DIM),
		.MAX_JUMPS (MAX_JUMPS)
	) sum_check (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.op          (op),
		.jump_index  (jump_index),
		.jump_pos    (jump_pos),
		.jump_weight (jump_weight),
		.row         (row),
		.col         (col),
		.elem_re     (elem_re),
		.elem_im     (elem_im),
		.node_pos    (node_pos),
		.first_node  (first_node),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.out_row     (out_row),
		.out_col     (out_col),
		.sum_re      (sum_re),
		.sum_im      (sum_im),
		.last        (last),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_data    (cfg_data),
		.fail_count  (fail_count),
		.results_due (results_due)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Receiver: stall at random 28 percent of the time, none at all while
	// recv_calm is set, and once hold off for HOLD_CYCLES on request so
	// the block backs up and stalls its request side.
	initial begin
		forever begin
			@(posedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES - 1) @(posedge clk);
			end else begin
				out_stall <= !recv_calm && ($urandom_range(99) < 28);
			end
		end
	end

	// Watchdog: give up when no channel has moved for too long.
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
			quiet <= 0;
		end else begin
			quiet <= quiet + 1;
			if (quiet >= WATCHDOG_LIMIT) begin
				$display("matrix_jump_step_accumulate_unit: mismatch");
				$finish;
			end
		end
	end

	function automatic logic entry_ready(input int j);
		return hdr_seen[j] && (&cells_seen[j]);
	endfunction

	// Fully random request: every field bit gets exercised through these.
	function automatic req_t noise_req();
		req_t q;
		q.op = 2'($urandom_range(3));
		q.idx = IDX_W'($urandom);
		q.jpos = POS_W'($urandom);
		q.wgt = WGT_W'($urandom);
		q.r = RC_W'($urandom);
		q.c = RC_W'($urandom);
		q.re = ELM_W'($urandom);
		q.im = ELM_W'($urandom);
		q.npos = POS_W'($urandom);
		q.first = 1'($urandom);
		return q;
	endfunction

	function automatic req_t hdr_req(input int idx, input int pos, input logic [WGT_W-1:0] w);
		req_t q;
		q = noise_req();
		q.op = OP_HDR;
		q.idx = IDX_W'(idx);
		q.jpos = POS_W'(pos);
		q.wgt = w;
		return q;
	endfunction

	function automatic req_t elem_req(input int idx, input int r, input int c,
			input logic [ELM_W-1:0] re, input logic [ELM_W-1:0] im);
		req_t q;
		q = noise_req();
		q.op = OP_ELEM;
		q.idx = IDX_W'(idx);
		q.r = RC_W'(r);
		q.c = RC_W'(c);
		q.re = re;
		q.im = im;
		return q;
	endfunction

	function automatic req_t node_req(input int pos, input logic first);
		req_t q;
		q = noise_req();
		q.op = OP_NODE;
		q.npos = POS_W'(pos);
		q.first = first;
		return q;
	endfunction

	// Offer one request and hold it until accepted. A node that would make
	// the block look at an unwritten jump gets first_node forced, which
	// restarts it at entry 0 (always written once jump_count is nonzero).
	task automatic send(input req_t q);
		int nj;
		if (q.op == OP_NODE) begin
			nj = q.first ? 0 : ptr_seen;
			if (nj < count_seen && !entry_ready(nj)) begin
				q.first = 1'b1;
				nj = 0;
			end
			if (nj < count_seen && pos_seen[nj] <= q.npos)
				nj++;
			ptr_seen = nj;
			items_sent++;
		end else if (q.op == OP_HDR) begin
			hdr_seen[q.idx] = 1'b1;
			pos_seen[q.idx] = q.jpos;
			items_sent++;
		end else if (q.op == OP_ELEM && q.r < DIM && q.c < DIM) begin
			cells_seen[q.idx][q.r*DIM + q.c] = 1'b1;
			items_sent++;
		end
		// idle a random number of cycles first, unless calm
		if (!send_calm && $urandom_range(99) < 28) begin
			in_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < 28);
		end
		in_valid <= 1'b1;
		op <= q.op;
		jump_index <= q.idx;
		jump_pos <= q.jpos;
		jump_weight <= q.wgt;
		row <= q.r;
		col <= q.c;
		elem_re <= q.re;
		elem_im <= q.im;
		node_pos <= q.npos;
		first_node <= q.first;
		@(posedge clk);
		while (in_stall) @(posedge clk);
	endtask

	// Drain everything, let table writes settle, then write jump_count.
	task automatic set_jump_count(input logic [JC_W-1:0] v);
		in_valid <= 1'b0;
		@(posedge clk);
		while (results_due != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= v;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		count_seen = (v > MAX_JUMPS) ? MAX_JUMPS : int'(v);
	endtask

	initial begin
		int k;
		int n;
		int step;
		int jpos;
		int npos;
		int phase;
		logic [JC_W-1:0] jc;
		logic signed [WGT_W-1:0] w;
		req_t q;

		for (int j = 0; j < MAX_JUMPS; j++) begin
			hdr_seen[j] = 1'b0;
			cells_seen[j] = '0;
		end

		// hold reset asserted, then release
		arst_n = 1'b0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// ---- directed ----
		// node with no jumps loaded: all-zero sum
		send(node_req(0, 1'b1));
		// spare opcode: no results
		q = noise_req();
		q.op = OP_SPARE;
		send(q);
		// three jumps at the most negative weight with extreme elements; three
		// adds push the real part past the top and the imaginary past the bottom
		send(hdr_req(0, 0, 32'sh8000_0000));
		send(hdr_req(1, 1, 32'sh8000_0000));
		send(hdr_req(2, 65536, 32'sh8000_0000));
		for (int j = 0; j < 3; j++)
			for (int e = 0; e < CELLS; e++)
				send(elem_req(j, e / DIM, e % DIM, 16'sh8000, 16'sh7FFF));
		// row or column outside the matrix: dropped by the block
		send(elem_req(0, 2, 0, 16'sh1234, 16'sh4321));
		send(elem_req(0, 1, 3, 16'sh1234, 16'sh4321));
		// count above the table size saturates
		set_jump_count(9'd511);
		send(node_req(0, 1'b1));        // takes jump 0
		send(node_req(0, 1'b0));        // jump 1 lies beyond: no add
		send(node_req(1, 1'b0));        // takes jump 1
		send(node_req(131071, 1'b0));   // position above 1.0, takes jump 2, saturates
		send(node_req(65536, 1'b0));    // next jump unwritten: restarted

		// ---- random phases: load a sorted jump set, set count, stream nodes ----
		items_sent = 0;
		phase = 0;
		while (items_sent < RANDOM_ITEMS) begin
			phase++;
			send_calm = (phase == 2 || phase == 4);
			recv_calm = (phase == 2);
			k = (phase % 5 == 0) ? $urandom_range(8, 24) : $urandom_range(1, 5);
			step = 65536 / (k + 1);

			jpos = 0;
			for (int j = 0; j < k; j++) begin
				jpos = jpos + $urandom_range(0, step);
				case ($urandom_range(3))
					0: w = WGT_W'($urandom);
					1: w = $urandom_range(1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
					default: w = WGT_W'($urandom_range(2097151)) - 32'sd1048576;
				endcase
				send(hdr_req(j, jpos, w));
				for (int e = 0; e < CELLS; e++)
					send(elem_req(j, e / DIM, e % DIM, ELM_W'($urandom), ELM_W'($urandom)));
				if ($urandom_range(9) == 0)
					send(noise_req());
			end

			if (phase == 3) begin
				jc = '0;
			end else begin
				case ($urandom_range(5))
					0: jc = JC_W'($urandom_range(0, k));
					1: jc = 9'd511;
					2: jc = 9'd256;
					3: jc = JC_W'($urandom);
					default: jc = JC_W'(k);
				endcase
			end
			set_jump_count(jc);

			// stall the output for a long stretch while nodes keep coming
			if (phase == 4)
				hold_req = 1'b1;

			n = k + $urandom_range(0, 4) + ((phase == 4) ? 16 : 0);
			npos = 0;
			for (int i = 0; i < n; i++) begin
				npos = npos + $urandom_range(0, step + step / 2);
				if (npos > 131071)
					npos = 131071;
				send(node_req(npos, (i == 0) || ($urandom_range(19) == 0)));
				if ($urandom_range(9) == 0)
					send(noise_req());
			end
		end

		// ---- wind down ----
		in_valid <= 1'b0;
		@(posedge clk);
		while (results_due != 0) @(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (fail_count == 0)
			$display("matrix_jump_step_accumulate_unit: match");
		else
			$display("matrix_jump_step_accumulate_unit: mismatch");
		$finish;
	end

endmodule

>>> filelist.f
design/mjsa_pkg.sv
design/mjsa_ctrl.sv
design/mjsa_dpath.sv
design/matrix_jump_step_accumulate_unit.sv
design/mjsa_check.sv
test/jump_sum_checker.sv
test/tb.sv
